// ----- rtl/chd_pkg.sv -----
package chd_pkg;

  // Code table geometry.
  localparam int unsigned NUM_LENGTHS      = 16;
  localparam int unsigned LEN_IDX_W        = 4;
  localparam int unsigned PLEN_W           = 5;
  localparam int unsigned CODE_W           = 16;
  localparam int unsigned MAX_CODE_LENGTH  = 16;
  localparam int unsigned COUNT_W          = 8;
  localparam int unsigned CFG_W            = 64;
  localparam int unsigned SYM_W            = 8;
  localparam int unsigned FIRST_W          = 17;
  localparam int unsigned OFFSET_W         = 12;
  localparam int unsigned NEXT_CODE_W      = 25;
  localparam int unsigned SPACE_W          = 21;
  localparam int unsigned TERM_W           = 24;
  localparam int unsigned IDX_W            = 13;
  localparam int unsigned DEF_SYMBOL_DEPTH = 256;

  localparam logic [SPACE_W-1:0] SPACE_FULL = 21'd65536;
  localparam logic [SPACE_W-1:0] SPACE_SAT  = 21'h1FFFFF;

  // Commands carried by an input item.
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_DECODE = 2'd2
  } cmd_e;

  // Status codes carried by a result item.
  typedef enum logic [2:0] {
    ST_NEED_MORE = 3'd0,
    ST_DONE      = 3'd1,
    ST_INVALID   = 3'd2,
    ST_BAD_TABLE = 3'd3,
    ST_STORED    = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  // Configuration register indexes.
  typedef enum logic {
    CFG_COUNTS_SHORT = 1'b0,
    CFG_COUNTS_LONG  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]       command;
    logic [SYM_W-1:0] symbol_byte;
    logic             code_bit;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [SYM_W-1:0] symbol;
  } out_item_t;

  // Table state seen by the decode datapath.
  typedef struct packed {
    logic                busy;
    logic                done;
    logic [SPACE_W-1:0]  used_space;
    logic [OFFSET_W-1:0] total;
  } tbl_info_t;

  // Number of codes of a given length; zero outside lengths 1 to 16.
  function automatic logic [COUNT_W-1:0] count_of_length(input logic [CFG_W-1:0] cnt_short,
                                                         input logic [CFG_W-1:0] cnt_long,
                                                         input logic [PLEN_W-1:0] len);
    logic [2*CFG_W-1:0]   all_counts;
    logic [LEN_IDX_W-1:0] k;
    all_counts = {cnt_long, cnt_short};
    k = LEN_IDX_W'(len - 5'd1);
    if (len == 5'd0 || len > 5'd16) begin
      return '0;
    end
    return all_counts[{k, 3'b000} +: COUNT_W];
  endfunction

endpackage

// ----- rtl/chd_ram.sv -----
module chd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/chd_table.sv -----
module chd_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [chd_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                clear_start_i,
  input  logic                                clear_ack_i,
  input  logic [chd_pkg::PLEN_W-1:0]          look_len_i,
  output logic [chd_pkg::COUNT_W-1:0]         look_count_o,
  output logic [chd_pkg::FIRST_W-1:0]         look_first_o,
  output logic [chd_pkg::OFFSET_W-1:0]        look_offset_o,
  output chd_pkg::tbl_info_t                  info_o
);
  import chd_pkg::*;

  localparam logic [LEN_IDX_W-1:0] LAST_STEP = LEN_IDX_W'(NUM_LENGTHS - 1);

  logic [CFG_W-1:0]       cnt_short_q, cnt_long_q;
  logic [FIRST_W-1:0]     first_q [NUM_LENGTHS];
  logic [OFFSET_W-1:0]    off_q   [NUM_LENGTHS];
  logic                   busy_q;
  logic [LEN_IDX_W-1:0]   step_q;
  logic [NEXT_CODE_W-1:0] code_q, code_d, code_sum;
  logic [OFFSET_W-1:0]    offset_q, offset_d;
  logic [SPACE_W-1:0]     space_q, space_d;
  logic [PLEN_W-1:0]      step_len;
  logic [COUNT_W-1:0]     step_n;
  logic [TERM_W-1:0]      term, space_sum;
  logic                   step_en;
  logic [LEN_IDX_W-1:0]   look_idx;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_short_q <= '0;
      cnt_long_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_COUNTS_SHORT: cnt_short_q <= cfg_data_i;
        CFG_COUNTS_LONG:  cnt_long_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // One length per sweep step: first code, store offset and code space.
  always_comb begin
    step_len  = PLEN_W'(step_q) + 5'd1;
    step_n    = count_of_length(cnt_short_q, cnt_long_q, step_len);
    term      = TERM_W'(step_n) << (5'd16 - step_len);
    space_sum = TERM_W'(space_q) + term;
    if (step_len <= PLEN_W'(MAX_CODE_LENGTH)) begin
      space_d = (space_sum > TERM_W'(SPACE_SAT)) ? SPACE_SAT : space_sum[SPACE_W-1:0];
    end else if (step_n != '0) begin
      space_d = SPACE_SAT;
    end else begin
      space_d = space_q;
    end
    offset_d = offset_q + OFFSET_W'(step_n);
    code_sum = code_q + NEXT_CODE_W'(step_n);
    code_d   = {code_sum[NEXT_CODE_W-2:0], 1'b0};
    // The last step waits until the result slot is free.
    step_en  = busy_q && (step_q != LAST_STEP || clear_ack_i);
  end

  // Sweep sequencer and per-length tables.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      step_q   <= '0;
      code_q   <= '0;
      offset_q <= '0;
      space_q  <= '0;
      for (int i = 0; i < NUM_LENGTHS; i++) begin
        first_q[i] <= '0;
        off_q[i]   <= '0;
      end
    end else if (clear_start_i) begin
      busy_q   <= 1'b1;
      step_q   <= '0;
      code_q   <= '0;
      offset_q <= '0;
      space_q  <= '0;
    end else if (step_en) begin
      first_q[step_q] <= code_q[FIRST_W-1:0];
      off_q[step_q]   <= offset_q;
      code_q          <= code_d;
      offset_q        <= offset_d;
      space_q         <= space_d;
      if (step_q == LAST_STEP) begin
        busy_q <= 1'b0;
      end else begin
        step_q <= step_q + 4'd1;
      end
    end
  end

  // Lookup for the decode datapath, by prefix length.
  assign look_idx      = LEN_IDX_W'(look_len_i - 5'd1);
  assign look_count_o  = count_of_length(cnt_short_q, cnt_long_q, look_len_i);
  assign look_first_o  = first_q[look_idx];
  assign look_offset_o = off_q[look_idx];

  // The offset accumulator ends as the total code count.
  assign info_o.busy       = busy_q;
  assign info_o.done       = step_en && step_q == LAST_STEP;
  assign info_o.used_space = space_q;
  assign info_o.total      = offset_q;

endmodule

// ----- rtl/canonical_huffman_bit_decoder.sv -----
// Channel   Direction  Signals                                   Item
// input     in         in_valid_i, in_stall_o, in_item_i         command, symbol_byte, code_bit
// output    out        out_valid_o, out_stall_i, out_item_o      status, symbol
// config    in         cfg_we_i, cfg_idx_i, cfg_data_i           code counts per length
//
// Load and decode items are taken one per cycle unless the input stalls; each
// result passes through the result slot and the output register, its symbol from the
// store's registered read. A clear item holds the input while the code lengths are
// swept, one per cycle but the last waits for a free result slot; its result follows.
// Reset is asynchronous and needs no clearing pass; the symbol store is not reset.
// With the output stalled, one more item is taken and held before the input stalls.
module canonical_huffman_bit_decoder #(
  parameter int unsigned SYMBOL_DEPTH = chd_pkg::DEF_SYMBOL_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [chd_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  chd_pkg::in_item_t         in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output chd_pkg::out_item_t        out_item_o
);
  import chd_pkg::*;

  localparam int unsigned ADDR_W = $clog2(SYMBOL_DEPTH);
  localparam int unsigned LOAD_W = $clog2(SYMBOL_DEPTH + 1);

  tbl_info_t           tbl_info;
  logic [COUNT_W-1:0]  look_count;
  logic [FIRST_W-1:0]  look_first;
  logic [OFFSET_W-1:0] look_offset;

  logic [LOAD_W-1:0]   loaded_q, loaded_d;
  logic [CODE_W-1:0]   prefix_q, prefix_d;
  logic [PLEN_W-1:0]   plen_q, plen_d;
  logic                s1_valid_q, s1_valid_d;
  status_e             s1_status_q, status_d;
  logic                s1_use_sym_q, use_sym_d;
  logic                out_valid_q;
  out_item_t           out_item_q;

  logic                in_accept, s1_adv, s1_load, clear_start, clear_ack;
  logic                wr_en, rd_en;
  logic [CODE_W-1:0]   pc_next;
  logic [PLEN_W-1:0]   plen_inc;
  logic [FIRST_W-1:0]  diff, aligned;
  logic [IDX_W-1:0]    sym_idx;
  logic                bad_table, hit, in_range, invalid;
  logic [SYM_W-1:0]    rd_data;

  // Handshake: the result slot moves when the output register is free or taken.
  assign s1_adv    = !out_valid_q || !out_stall_i;
  assign in_stall_o = tbl_info.busy || (s1_valid_q && !s1_adv);
  assign in_accept = in_valid_i && !in_stall_o;
  assign clear_ack = !s1_valid_q || s1_adv;

  chd_table u_table (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .clear_start_i (clear_start),
    .clear_ack_i   (clear_ack),
    .look_len_i    (plen_inc),
    .look_count_o  (look_count),
    .look_first_o  (look_first),
    .look_offset_o (look_offset),
    .info_o        (tbl_info)
  );

  // Decode datapath: extend the prefix by one bit and test it against its length.
  always_comb begin
    pc_next   = {prefix_q[CODE_W-2:0], in_item_i.code_bit};
    plen_inc  = (plen_q == 5'd16) ? 5'd16 : plen_q + 5'd1;
    diff      = FIRST_W'(pc_next) - look_first;
    hit       = look_count != '0 && FIRST_W'(pc_next) >= look_first &&
                diff < FIRST_W'(look_count);
    sym_idx   = IDX_W'(look_offset) + IDX_W'(diff[COUNT_W-1:0]);
    in_range  = sym_idx < IDX_W'(loaded_q);
    aligned   = FIRST_W'(pc_next) << (5'd16 - plen_inc);
    invalid   = SPACE_W'(aligned) >= tbl_info.used_space ||
                plen_inc >= PLEN_W'(MAX_CODE_LENGTH);
    bad_table = IDX_W'(tbl_info.total) != IDX_W'(loaded_q) ||
                tbl_info.used_space > SPACE_FULL;
  end

  // Command handling.
  always_comb begin
    status_d    = ST_NEED_MORE;
    use_sym_d   = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    clear_start = 1'b0;
    loaded_d    = loaded_q;
    prefix_d    = prefix_q;
    plen_d      = plen_q;
    if (in_accept) begin
      unique case (cmd_e'(in_item_i.command))
        CMD_CLEAR: begin
          clear_start = 1'b1;
          loaded_d    = '0;
          prefix_d    = '0;
          plen_d      = '0;
        end
        CMD_LOAD: begin
          if (loaded_q < LOAD_W'(SYMBOL_DEPTH)) begin
            wr_en    = 1'b1;
            loaded_d = loaded_q + 1'b1;
            status_d = ST_STORED;
          end else begin
            status_d = ST_FULL;
          end
        end
        CMD_DECODE: begin
          if (bad_table) begin
            status_d = ST_BAD_TABLE;
            prefix_d = '0;
            plen_d   = '0;
          end else if (hit) begin
            status_d  = ST_DONE;
            rd_en     = in_range;
            use_sym_d = in_range;
            prefix_d  = '0;
            plen_d    = '0;
          end else if (invalid) begin
            status_d = ST_INVALID;
            prefix_d = '0;
            plen_d   = '0;
          end else begin
            prefix_d = pc_next;
            plen_d   = plen_inc;
          end
        end
        default: ;
      endcase
    end
  end

  // The result slot takes the result of every non-clear item, or the clear result after the sweep.
  always_comb begin
    s1_load = (in_accept && in_item_i.command != CMD_CLEAR) || tbl_info.done;
    if (s1_load) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  chd_ram #(
    .WIDTH (SYM_W),
    .DEPTH (SYMBOL_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (loaded_q[ADDR_W-1:0]),
    .wdata_i (in_item_i.symbol_byte),
    .re_i    (rd_en),
    .raddr_i (sym_idx[ADDR_W-1:0]),
    .rdata_o (rd_data)
  );

  // Decoder state and result slot control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q    <= '0;
      prefix_q    <= '0;
      plen_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      loaded_q   <= loaded_d;
      prefix_q   <= prefix_d;
      plen_q     <= plen_d;
      s1_valid_q <= s1_valid_d;
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Result slot payload.
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_status_q  <= in_accept ? status_d : ST_NEED_MORE;
      s1_use_sym_q <= in_accept && use_sym_d;
    end
  end

  // Output register; the symbol comes from the store's read register.
  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_item_q.status <= s1_status_q;
      out_item_q.symbol <= s1_use_sym_q ? rd_data : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ----- rtl/chd_checker.sv -----
module chd_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_o,
  input  chd_pkg::in_item_t         in_item_i,
  input  logic                      out_valid_o,
  input  logic                      out_stall_i,
  input  chd_pkg::out_item_t        out_item_o
);
  import chd_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("result changed while stalled");

  // Only a decoded symbol carries a nonzero symbol byte.
  a_symbol_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != ST_DONE |-> out_item_o.symbol == '0)
    else $error("symbol set without a decoded code");

  // A clear item starts the table sweep, which holds the input.
  a_clear_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.command == CMD_CLEAR |=> in_stall_o)
    else $error("input taken during table sweep");

endmodule

bind canonical_huffman_bit_decoder chd_checker u_chd_checker (.*);
